// ===== rtl/core/flrc_pkg.sv =====
package flrc_pkg;

   // request kinds
   typedef enum logic [0:0] {
      KIND_LOOKUP = 1'b0,
      KIND_FILL   = 1'b1
   } kind_type;

   // fixed payload widths on the channels
   localparam int unsigned REQ_KEY_BITS   = 32;
   localparam int unsigned REQ_VALUE_BITS = 32;
   localparam int unsigned RSP_VALUE_BITS = 32;
   localparam int unsigned RSP_SLOT_BITS  = 4;

endpackage

// ===== rtl/core/flrc_req_if.sv =====
interface flrc_req_if;

   logic                                valid;
   logic                                ready;
   flrc_pkg::kind_type                  kind;
   logic [flrc_pkg::REQ_KEY_BITS-1:0]   key;
   logic [flrc_pkg::REQ_VALUE_BITS-1:0] fill_value;

   modport source (output valid, output kind, output key, output fill_value, input ready);
   modport sink   (input valid, input kind, input key, input fill_value, output ready);

endinterface

// ===== rtl/core/flrc_rsp_if.sv =====
interface flrc_rsp_if;

   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [flrc_pkg::RSP_VALUE_BITS-1:0] read_value;
   logic [flrc_pkg::RSP_SLOT_BITS-1:0]  slot;

   modport source (output valid, output hit, output read_value, output slot, input ready);
   modport sink   (input valid, input hit, input read_value, input slot, output ready);

endinterface

// ===== rtl/core/fifo_replacement_lookup_cache_unit.sv =====
// channel   | role   | word
// ----------+--------+--------------------------------------------
// req_port  | sink   | kind, key, fill_value
// rsp_port  | source | hit, read_value, slot
//
// one word per cycle sustained while the response is not stalled; a request reaches the response
// through the input register, then parallel tag compare and update into the response register
// table state changes when a word leaves the input register, so the next word sees it
// synchronous reset clears slot valid bits, fill pointer and both valid flags
// a stalled response holds the input register; req_port.ready drops only then
module fifo_replacement_lookup_cache_unit #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   flrc_req_if.sink    req_port,
   flrc_rsp_if.source  rsp_port
);

   localparam int unsigned SLOT_BITS = $clog2(ENTRIES);
   localparam int unsigned KEY_WIDE  =
      (KEY_BITS > flrc_pkg::REQ_KEY_BITS) ? KEY_BITS : flrc_pkg::REQ_KEY_BITS;
   localparam int unsigned VAL_IN_WIDE =
      (VALUE_BITS > flrc_pkg::REQ_VALUE_BITS) ? VALUE_BITS : flrc_pkg::REQ_VALUE_BITS;
   localparam int unsigned VAL_OUT_WIDE =
      (VALUE_BITS > flrc_pkg::RSP_VALUE_BITS) ? VALUE_BITS : flrc_pkg::RSP_VALUE_BITS;
   localparam int unsigned SLOT_WIDE =
      (SLOT_BITS > flrc_pkg::RSP_SLOT_BITS) ? SLOT_BITS : flrc_pkg::RSP_SLOT_BITS;

   // input register
   logic                       in_valid_ff, in_valid_in;
   flrc_pkg::kind_type         in_kind_ff;
   logic [KEY_BITS-1:0]        in_key_ff;
   logic [VALUE_BITS-1:0]      in_value_ff;

   // response register
   logic                                 out_valid_ff, out_valid_in;
   logic                                 out_hit_ff;
   logic [flrc_pkg::RSP_VALUE_BITS-1:0]  out_value_ff;
   logic [flrc_pkg::RSP_SLOT_BITS-1:0]   out_slot_ff;

   // table state
   logic [KEY_BITS-1:0]   key_store_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_store_ff [ENTRIES];
   logic [ENTRIES-1:0]    slot_valid_ff, slot_valid_in;
   logic [SLOT_BITS-1:0]  fill_ptr_ff, fill_ptr_in;

   logic                  out_free;
   logic                  advance;
   logic                  accept;
   logic                  is_fill;
   logic                  hit;
   logic [ENTRIES-1:0]    hit_onehot;
   logic [SLOT_BITS-1:0]  hit_index;
   logic [SLOT_BITS-1:0]  slot_sel;
   logic [VALUE_BITS-1:0] hit_value;
   logic [KEY_WIDE-1:0]   req_key_wide;
   logic [VAL_IN_WIDE-1:0] req_value_wide;
   logic [VAL_OUT_WIDE-1:0] rsp_value_wide;
   logic [SLOT_WIDE-1:0]  rsp_slot_wide;

   // handshake flow
   assign out_free       = !out_valid_ff || rsp_port.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_port.ready = !in_valid_ff || out_free;
   assign accept         = req_port.valid && req_port.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_port.ready);

   // payload trimmed to storage width
   assign req_key_wide   = KEY_WIDE'(req_port.key);
   assign req_value_wide = VAL_IN_WIDE'(req_port.fill_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff  <= req_port.kind;
         in_key_ff   <= req_key_wide[KEY_BITS-1:0];
         in_value_ff <= req_value_wide[VALUE_BITS-1:0];
      end
   end

   // tag compare
   flrc_match #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_match (
      .keys       (key_store_ff),
      .valid      (slot_valid_ff),
      .key        (in_key_ff),
      .hit        (hit),
      .hit_onehot (hit_onehot),
      .hit_index  (hit_index)
   );

   // value of the hit slot, and-or over the one-hot select
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | (value_store_ff[i] & {VALUE_BITS{hit_onehot[i]}});
      end
   end

   assign is_fill  = (in_kind_ff == flrc_pkg::KIND_FILL);
   assign slot_sel = hit ? hit_index : fill_ptr_ff;

   // response fields
   assign rsp_value_wide = (!is_fill && hit) ? VAL_OUT_WIDE'(hit_value) : '0;
   assign rsp_slot_wide  = SLOT_WIDE'(slot_sel);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hit_ff   <= hit;
         out_value_ff <= rsp_value_wide[flrc_pkg::RSP_VALUE_BITS-1:0];
         out_slot_ff  <= rsp_slot_wide[flrc_pkg::RSP_SLOT_BITS-1:0];
      end
   end

   // valid bits and fill pointer, new fill takes the pointed slot
   always_comb begin
      slot_valid_in = slot_valid_ff;
      fill_ptr_in   = fill_ptr_ff;
      if (advance && is_fill && !hit) begin
         slot_valid_in[fill_ptr_ff] = 1'b1;
         if (fill_ptr_ff == SLOT_BITS'(ENTRIES - 1)) begin
            fill_ptr_in = '0;
         end else begin
            fill_ptr_in = fill_ptr_ff + SLOT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         fill_ptr_ff   <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         fill_ptr_ff   <= fill_ptr_in;
      end
   end

   // store writes, hit fill rewrites value in place
   always_ff @(posedge clock) begin
      if (advance && is_fill) begin
         value_store_ff[slot_sel] <= in_value_ff;
         if (!hit) begin
            key_store_ff[fill_ptr_ff] <= in_key_ff;
         end
      end
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.hit        = out_hit_ff;
   assign rsp_port.read_value = out_value_ff;
   assign rsp_port.slot       = out_slot_ff;

endmodule

// ===== rtl/core/flrc_match.sv =====
module flrc_match #(
   parameter int unsigned ENTRIES  = 16,
   parameter int unsigned KEY_BITS = 32,
   localparam int unsigned SLOT_BITS = $clog2(ENTRIES)
) (
   input  logic [KEY_BITS-1:0]  keys [ENTRIES],
   input  logic [ENTRIES-1:0]   valid,
   input  logic [KEY_BITS-1:0]  key,
   output logic                 hit,
   output logic [ENTRIES-1:0]   hit_onehot,
   output logic [SLOT_BITS-1:0] hit_index
);

   logic [ENTRIES-1:0] match;

   // parallel compare against every valid slot
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid[i] && (keys[i] == key);
      end
   end

   // keep only the lowest matching slot
   assign hit_onehot = match & (~match + ENTRIES'(1));
   assign hit        = |match;

   // encode the one-hot slot into an index
   always_comb begin
      hit_index = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_onehot[i]) begin
            hit_index = hit_index | SLOT_BITS'(i);
         end
      end
   end

endmodule
